### rtl/tcbw_pkg.sv
`default_nettype none

package tcbw_pkg;

	localparam int CP_W   = 21;
	localparam int ATTR_W = 8;

	localparam logic [1:0] ACT_PUT   = 2'd0;
	localparam logic [1:0] ACT_MOVE  = 2'd1;
	localparam logic [1:0] ACT_CLEAR = 2'd2;
	localparam logic [1:0] ACT_READ  = 2'd3;

	localparam logic [CP_W-1:0] BLANK_CODE = 21'h000020;
	localparam logic [CP_W-1:0] CH_CR      = 21'h00000D;
	localparam logic [CP_W-1:0] CH_LF      = 21'h00000A;
	localparam logic [CP_W-1:0] CH_BS      = 21'h000008;
	localparam logic [CP_W-1:0] CH_TAB     = 21'h000009;

	localparam logic CFG_COLS = 1'b0;
	localparam logic CFG_ROWS = 1'b1;

	localparam logic [7:0] COLS_RESET = 8'd80;
	localparam logic [6:0] ROWS_RESET = 7'd25;

	typedef struct packed {
		logic [CP_W-1:0]   cp;
		logic [ATTR_W-1:0] attr;
	} cell_t;

	typedef struct packed {
		logic              status;
		logic              is_write;
		logic [5:0]        cell_row;
		logic [6:0]        cell_col;
		logic [CP_W-1:0]   cell_codepoint;
		logic [ATTR_W-1:0] cell_attr;
		logic [5:0]        pen_row;
		logic [6:0]        pen_col;
		logic              last;
	} result_t;

endpackage

`default_nettype wire

### rtl/text_cell_buffer_writer.sv
`default_nettype none

// Character-cell screen store (MAX_ROWS x MAX_COLS cells of codepoint + attribute) with a
// draw cursor, held in one single-port-write, registered-read memory. A put of a printable
// or control character gives one result; a tab writes one to TAB_STOP spaces, one result
// each; a read waits in ST_READ for the registered memory read; a clear walks the whole
// memory one cell per cycle and then returns its result. After reset the same walk (8192
// cells at the defaults) blanks the store while no item is taken; configuration writes are
// taken at any time and home the cursor.
module text_cell_buffer_writer #(
	parameter int MAX_COLS = 128,
	parameter int MAX_ROWS = 64,
	parameter int TAB_STOP = 4
) (
	input  wire logic        clk,
	input  wire logic        arst_n,

	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [7:0]  cfg_data,

	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  action,
	input  wire logic [20:0] codepoint,
	input  wire logic [6:0]  row,
	input  wire logic [6:0]  col,
	input  wire logic [7:0]  attr,

	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             status,
	output logic             is_write,
	output logic [5:0]       cell_row,
	output logic [6:0]       cell_col,
	output logic [20:0]      cell_codepoint,
	output logic [7:0]       cell_attr,
	output logic [5:0]       pen_row,
	output logic [6:0]       pen_col,
	output logic             last
);

	localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int CW1   = CW + 1;
	localparam int RW1   = RW + 1;
	localparam int CELLS = MAX_ROWS * MAX_COLS;
	localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
	localparam int NW    = $clog2(TAB_STOP + 1);

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_TAB,
		ST_READ,
		ST_CLEAR,
		ST_CLR_RES
	} state_t;

	state_t                 state_q;
	logic [7:0]             scols_q;
	logic [6:0]             srows_q;
	logic [RW-1:0]          cur_row_q;
	logic [CW-1:0]          cur_col_q;
	logic [AW-1:0]          clr_q;
	logic [NW-1:0]          tab_n_q;
	logic [7:0]             tab_attr_q;
	logic [RW-1:0]          rrow_q;
	logic [CW-1:0]          rcol_q;
	logic                   out_valid_q;
	tcbw_pkg::result_t      res_q;

	tcbw_pkg::cell_t        mem [CELLS];
	tcbw_pkg::cell_t        rd_q;

	logic [CW1-1:0]         ucols;
	logic [RW1-1:0]         urows;
	logic [MAX_COLS-1:0]    stop_map;

	logic                   out_free;
	logic                   acc;
	logic                   sweeping;
	logic [CW1-1:0]         col_inc;
	logic [RW1-1:0]         row_inc;
	logic [RW-1:0]          adv_row;
	logic [CW-1:0]          adv_col;
	logic [AW-1:0]          cur_addr;
	logic [AW-1:0]          tgt_addr;
	logic                   tgt_bad;
	logic                   is_ctrl;
	logic                   put_wr;
	tcbw_pkg::cell_t        put_cell;
	logic [NW-1:0]          tab_n_next;
	logic                   tab_last;
	logic                   mem_we;
	logic [AW-1:0]          mem_waddr;
	tcbw_pkg::cell_t        mem_wdata;
	logic                   mem_re;

	// columns where a tab run stops, fixed at elaboration
	for (genvar i = 0; i < MAX_COLS; i++) begin : g_stop
		assign stop_map[i] = ((i % TAB_STOP) == 0);
	end

	always_comb begin
		if (scols_q == 8'd0) begin
			ucols = CW1'(1);
		end else if ({1'b0, scols_q} > 9'(MAX_COLS)) begin
			ucols = CW1'(MAX_COLS);
		end else begin
			ucols = CW1'(scols_q);
		end
		if (srows_q == 7'd0) begin
			urows = RW1'(1);
		end else if ({1'b0, srows_q} > 8'(MAX_ROWS)) begin
			urows = RW1'(MAX_ROWS);
		end else begin
			urows = RW1'(srows_q);
		end
	end

	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == ST_IDLE) && out_free;
	assign acc      = in_valid && in_ready;
	assign sweeping = (state_q == ST_INIT) || (state_q == ST_CLEAR);

	// cursor after one cell write: wrap to next row, stick on the last row
	always_comb begin
		col_inc = {1'b0, cur_col_q} + CW1'(1);
		row_inc = {1'b0, cur_row_q} + RW1'(1);
		if (col_inc >= ucols) begin
			adv_col = '0;
			adv_row = (row_inc < urows) ? row_inc[RW-1:0] : cur_row_q;
		end else begin
			adv_col = col_inc[CW-1:0];
			adv_row = cur_row_q;
		end
	end

	assign cur_addr = AW'(AW'(cur_row_q) * AW'(MAX_COLS)) + AW'(cur_col_q);
	assign tgt_addr = AW'(AW'(row) * AW'(MAX_COLS)) + AW'(col);
	assign tgt_bad  = ({1'b0, row} >= 8'(urows)) || ({2'b0, col} >= 9'(ucols));

	assign is_ctrl = (codepoint == tcbw_pkg::CH_CR) || (codepoint == tcbw_pkg::CH_LF)
		|| (codepoint == tcbw_pkg::CH_BS);

	always_comb begin
		put_wr = (acc && (action == tcbw_pkg::ACT_PUT) && !is_ctrl)
			|| ((state_q == ST_TAB) && out_free);
		if (state_q == ST_TAB) begin
			put_cell.cp   = tcbw_pkg::BLANK_CODE;
			put_cell.attr = tab_attr_q;
		end else begin
			put_cell.cp   = (codepoint >= tcbw_pkg::BLANK_CODE) ? codepoint
				: tcbw_pkg::BLANK_CODE;
			put_cell.attr = attr;
		end
		tab_n_next = (state_q == ST_TAB) ? tab_n_q + NW'(1) : NW'(1);
		tab_last   = stop_map[adv_col] || (tab_n_next >= NW'(TAB_STOP));
	end

	always_comb begin
		mem_we    = sweeping || put_wr;
		mem_waddr = sweeping ? clr_q : cur_addr;
		if (sweeping) begin
			mem_wdata.cp   = tcbw_pkg::BLANK_CODE;
			mem_wdata.attr = '0;
		end else begin
			mem_wdata = put_cell;
		end
		mem_re = acc && (action == tcbw_pkg::ACT_READ) && !tgt_bad;
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rd_q <= mem[tgt_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			scols_q     <= tcbw_pkg::COLS_RESET;
			srows_q     <= tcbw_pkg::ROWS_RESET;
			cur_row_q   <= '0;
			cur_col_q   <= '0;
			clr_q       <= '0;
			tab_n_q     <= '0;
			tab_attr_q  <= '0;
			rrow_q      <= '0;
			rcol_q      <= '0;
			out_valid_q <= 1'b0;
			res_q       <= '0;
		end else begin
			if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_INIT: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(CELLS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (acc) begin
						res_q       <= '0;
						res_q.last  <= 1'b1;
						out_valid_q <= 1'b1;
						unique case (action)
							tcbw_pkg::ACT_PUT: begin
								if (codepoint == tcbw_pkg::CH_CR) begin
									cur_col_q     <= '0;
									res_q.pen_row <= 6'(cur_row_q);
									res_q.pen_col <= '0;
								end else if (codepoint == tcbw_pkg::CH_LF) begin
									cur_col_q     <= '0;
									res_q.pen_col <= '0;
									if (row_inc < urows) begin
										cur_row_q     <= row_inc[RW-1:0];
										res_q.pen_row <= 6'(row_inc);
									end else begin
										res_q.pen_row <= 6'(cur_row_q);
									end
								end else if (codepoint == tcbw_pkg::CH_BS) begin
									res_q.pen_row <= 6'(cur_row_q);
									if (cur_col_q != '0) begin
										cur_col_q     <= cur_col_q - CW'(1);
										res_q.pen_col <= 7'(cur_col_q - CW'(1));
									end else begin
										res_q.pen_col <= '0;
									end
								end else begin
									cur_row_q            <= adv_row;
									cur_col_q            <= adv_col;
									res_q.is_write       <= 1'b1;
									res_q.cell_row       <= 6'(cur_row_q);
									res_q.cell_col       <= 7'(cur_col_q);
									res_q.cell_codepoint <= put_cell.cp;
									res_q.cell_attr      <= put_cell.attr;
									res_q.pen_row        <= 6'(adv_row);
									res_q.pen_col        <= 7'(adv_col);
									if (codepoint == tcbw_pkg::CH_TAB) begin
										res_q.last <= tab_last;
										tab_n_q    <= tab_n_next;
										tab_attr_q <= attr;
										if (!tab_last) begin
											state_q <= ST_TAB;
										end
									end
								end
							end
							tcbw_pkg::ACT_MOVE: begin
								if (tgt_bad) begin
									res_q.status  <= 1'b1;
									res_q.pen_row <= 6'(cur_row_q);
									res_q.pen_col <= 7'(cur_col_q);
								end else begin
									cur_row_q     <= RW'(row);
									cur_col_q     <= CW'(col);
									res_q.pen_row <= 6'(row);
									res_q.pen_col <= 7'(col);
								end
							end
							tcbw_pkg::ACT_CLEAR: begin
								out_valid_q <= !out_ready && out_valid_q;
								cur_row_q   <= '0;
								cur_col_q   <= '0;
								clr_q       <= '0;
								state_q     <= ST_CLEAR;
							end
							tcbw_pkg::ACT_READ: begin
								if (tgt_bad) begin
									res_q.status  <= 1'b1;
									res_q.pen_row <= 6'(cur_row_q);
									res_q.pen_col <= 7'(cur_col_q);
								end else begin
									out_valid_q <= !out_ready && out_valid_q;
									rrow_q      <= RW'(row);
									rcol_q      <= CW'(col);
									state_q     <= ST_READ;
								end
							end
							default: ;
						endcase
					end
				end
				ST_TAB: begin
					if (out_free) begin
						cur_row_q            <= adv_row;
						cur_col_q            <= adv_col;
						tab_n_q              <= tab_n_next;
						out_valid_q          <= 1'b1;
						res_q                <= '0;
						res_q.is_write       <= 1'b1;
						res_q.cell_row       <= 6'(cur_row_q);
						res_q.cell_col       <= 7'(cur_col_q);
						res_q.cell_codepoint <= put_cell.cp;
						res_q.cell_attr      <= put_cell.attr;
						res_q.pen_row        <= 6'(adv_row);
						res_q.pen_col        <= 7'(adv_col);
						res_q.last           <= tab_last;
						if (tab_last) begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_READ: begin
					if (out_free) begin
						out_valid_q          <= 1'b1;
						res_q                <= '0;
						res_q.cell_row       <= 6'(rrow_q);
						res_q.cell_col       <= 7'(rcol_q);
						res_q.cell_codepoint <= rd_q.cp;
						res_q.cell_attr      <= rd_q.attr;
						res_q.pen_row        <= 6'(cur_row_q);
						res_q.pen_col        <= 7'(cur_col_q);
						res_q.last           <= 1'b1;
						state_q              <= ST_IDLE;
					end
				end
				ST_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(CELLS - 1)) begin
						state_q <= ST_CLR_RES;
					end
				end
				ST_CLR_RES: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						res_q       <= '0;
						res_q.last  <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase

			// register writes home the cursor; issue them only while idle (the block itself does not enforce this)
			if (cfg_we) begin
				cur_row_q <= '0;
				cur_col_q <= '0;
				if (cfg_index == tcbw_pkg::CFG_COLS) begin
					scols_q <= cfg_data;
				end else begin
					srows_q <= cfg_data[6:0];
				end
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = res_q.status;
	assign is_write       = res_q.is_write;
	assign cell_row       = res_q.cell_row;
	assign cell_col       = res_q.cell_col;
	assign cell_codepoint = res_q.cell_codepoint;
	assign cell_attr      = res_q.cell_attr;
	assign pen_row        = res_q.pen_row;
	assign pen_col        = res_q.pen_col;
	assign last           = res_q.last;

`ifndef SYNTH
	a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		sweeping |-> !in_ready)
		else $error("item taken while store is being blanked");

	a_tab_has_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_TAB) |-> out_valid_q)
		else $error("tab run without a pending result");

	a_cursor_in_screen: assert property (@(posedge clk) disable iff (!arst_n)
		({1'b0, cur_col_q} < ucols) && ({1'b0, cur_row_q} < urows))
		else $error("cursor outside the screen");

	a_read_follows: assert property (@(posedge clk) disable iff (!arst_n)
		mem_re |=> (state_q == ST_READ))
		else $error("memory read without read wait state");
`endif

endmodule

`default_nettype wire

### dv/text_cell_buffer_writer_tb.sv
`default_nettype none

module text_cell_buffer_writer_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int GRID_COLS      = 128;
	localparam int GRID_ROWS      = 64;
	localparam int TAB_WIDTH      = 4;
	localparam int STALL_LIMIT    = 30000;
	localparam int RAND_PER_PHASE = 38;
	localparam int SETTLE_CYCLES  = 8;
	localparam int NUM_PHASES     = 6;

	typedef struct packed {
		logic [1:0]                  act;
		logic [tcbw_pkg::CP_W-1:0]   cp;
		logic [6:0]                  r;
		logic [6:0]                  c;
		logic [tcbw_pkg::ATTR_W-1:0] at;
		logic                        known;
		tcbw_pkg::result_t           want;
	} stim_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic cfg_index;
	logic [7:0] cfg_data;
	logic in_valid;
	logic in_ready;
	logic [1:0] action;
	logic [20:0] codepoint;
	logic [6:0] row;
	logic [6:0] col;
	logic [7:0] attr;
	logic out_valid;
	logic out_ready = 1'b0;
	logic status;
	logic is_write;
	logic [5:0] cell_row;
	logic [6:0] cell_col;
	logic [20:0] cell_codepoint;
	logic [7:0] cell_attr;
	logic [5:0] pen_row;
	logic [6:0] pen_col;
	logic last;

	// typed expectation travels with the item it belongs to
	logic tag_known;
	tcbw_pkg::result_t tag_want;

	// screen model
	logic [tcbw_pkg::CP_W-1:0] glyph_mem [GRID_ROWS*GRID_COLS];
	logic [tcbw_pkg::ATTR_W-1:0] attr_mem [GRID_ROWS*GRID_COLS];
	int cur_r, cur_c;
	int last_wr_r, last_wr_c;
	logic [7:0] cols_reg;
	logic [6:0] rows_reg;

	tcbw_pkg::result_t pending_results[$];
	stim_t directed_rows[$];
	int err_count = 0;
	int quiet_cycles = 0;
	int stall_left = 0;
	bit idle_on = 1'b1;

	text_cell_buffer_writer dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.action(action),
		.codepoint(codepoint),
		.row(row),
		.col(col),
		.attr(attr),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.is_write(is_write),
		.cell_row(cell_row),
		.cell_col(cell_col),
		.cell_codepoint(cell_codepoint),
		.cell_attr(cell_attr),
		.pen_row(pen_row),
		.pen_col(pen_col),
		.last(last)
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	function automatic int live_cols();
		if (cols_reg == 8'd0) return 1;
		if (int'(cols_reg) > GRID_COLS) return GRID_COLS;
		return int'(cols_reg);
	endfunction

	function automatic int live_rows();
		if (rows_reg == 7'd0) return 1;
		if (int'(rows_reg) > GRID_ROWS) return GRID_ROWS;
		return int'(rows_reg);
	endfunction

	task automatic blank_model();
		for (int i = 0; i < GRID_ROWS*GRID_COLS; i++) begin
			glyph_mem[i] = tcbw_pkg::BLANK_CODE;
			attr_mem[i] = '0;
		end
		cur_r = 0;
		cur_c = 0;
	endtask

	// write at the cursor, then advance with wrap; the last row never scrolls
	task automatic store_cell(input logic [tcbw_pkg::CP_W-1:0] code,
			input logic [tcbw_pkg::ATTR_W-1:0] at, output tcbw_pkg::result_t res);
		int idx;
		idx = cur_r*GRID_COLS + cur_c;
		glyph_mem[idx] = (code >= tcbw_pkg::BLANK_CODE) ? code : tcbw_pkg::BLANK_CODE;
		attr_mem[idx] = at;
		res = '0;
		res.is_write = 1'b1;
		res.cell_row = 6'(cur_r);
		res.cell_col = 7'(cur_c);
		res.cell_codepoint = glyph_mem[idx];
		res.cell_attr = at;
		last_wr_r = cur_r;
		last_wr_c = cur_c;
		cur_c++;
		if (cur_c >= live_cols()) begin
			cur_c = 0;
			if (cur_r + 1 < live_rows())
				cur_r++;
		end
		res.pen_row = 6'(cur_r);
		res.pen_col = 7'(cur_c);
	endtask

	task automatic predict_screen_item(input logic [1:0] act,
			input logic [tcbw_pkg::CP_W-1:0] cp, input logic [6:0] r, input logic [6:0] c,
			input logic [tcbw_pkg::ATTR_W-1:0] at);
		tcbw_pkg::result_t res;
		int n;
		int idx;
		res = '0;
		case (act)
			tcbw_pkg::ACT_PUT: begin
				if (cp == tcbw_pkg::CH_TAB) begin
					n = 0;
					do begin
						store_cell(tcbw_pkg::BLANK_CODE, at, res);
						n++;
						res.last = (cur_c % TAB_WIDTH == 0) || (n >= TAB_WIDTH);
						pending_results.push_back(res);
					end while (cur_c % TAB_WIDTH != 0 && n < TAB_WIDTH);
					return;
				end else if (cp == tcbw_pkg::CH_CR) begin
					cur_c = 0;
				end else if (cp == tcbw_pkg::CH_LF) begin
					cur_c = 0;
					if (cur_r + 1 < live_rows())
						cur_r++;
				end else if (cp == tcbw_pkg::CH_BS) begin
					if (cur_c > 0)
						cur_c--;
				end else begin
					store_cell(cp, at, res);
				end
			end
			tcbw_pkg::ACT_MOVE: begin
				if (int'(r) >= live_rows() || int'(c) >= live_cols()) begin
					res.status = 1'b1;
				end else begin
					cur_r = int'(r);
					cur_c = int'(c);
				end
			end
			tcbw_pkg::ACT_CLEAR: begin
				blank_model();
			end
			default: begin
				if (int'(r) >= live_rows() || int'(c) >= live_cols()) begin
					res.status = 1'b1;
				end else begin
					idx = int'(r)*GRID_COLS + int'(c);
					res.cell_row = 6'(r);
					res.cell_col = c;
					res.cell_codepoint = glyph_mem[idx];
					res.cell_attr = attr_mem[idx];
				end
			end
		endcase
		res.pen_row = 6'(cur_r);
		res.pen_col = 7'(cur_c);
		res.last = 1'b1;
		pending_results.push_back(res);
	endtask

	task automatic log_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want_v);
		$display("%0t: mismatch on %s: got %0h, expected %0h", $time, what, got, want_v);
		err_count++;
	endtask

	task automatic check_field(input string what, input logic [31:0] got,
			input logic [31:0] want_v);
		if (got !== want_v)
			log_mismatch(what, got, want_v);
	endtask

	always @(posedge clk) begin : scoreboard
		tcbw_pkg::result_t want;
		if (arst_n && in_valid && in_ready) begin
			predict_screen_item(action, codepoint, row, col, attr);
			if (tag_known) begin
				void'(pending_results.pop_back());
				pending_results.push_back(tag_want);
			end
		end
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				log_mismatch("result with nothing pending", 32'd0, 32'd0);
			end else begin
				want = pending_results.pop_front();
				check_field("status", 32'(status), 32'(want.status));
				check_field("is_write", 32'(is_write), 32'(want.is_write));
				check_field("cell_row", 32'(cell_row), 32'(want.cell_row));
				check_field("cell_col", 32'(cell_col), 32'(want.cell_col));
				check_field("cell_codepoint", 32'(cell_codepoint), 32'(want.cell_codepoint));
				check_field("cell_attr", 32'(cell_attr), 32'(want.cell_attr));
				check_field("pen_row", 32'(pen_row), 32'(want.pen_row));
				check_field("pen_col", 32'(pen_col), 32'(want.pen_col));
				check_field("last", 32'(last), 32'(want.last));
			end
		end
	end

	// clear and the post-reset blanking pass are long, so the limit is generous
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("text_cell_buffer_writer regression: fail");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else if (idle_on && $urandom_range(0, 5) == 0) begin
			stall_left = $urandom_range(0, 6);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	function automatic tcbw_pkg::result_t fixed_result(input int st, input int wr,
			input int r, input int c, input int cp, input int at, input int cr,
			input int cc);
		tcbw_pkg::result_t res;
		res.status = 1'(st);
		res.is_write = 1'(wr);
		res.cell_row = 6'(r);
		res.cell_col = 7'(c);
		res.cell_codepoint = 21'(cp);
		res.cell_attr = 8'(at);
		res.pen_row = 6'(cr);
		res.pen_col = 7'(cc);
		res.last = 1'b1;
		return res;
	endfunction

	task automatic add_row(input logic [1:0] act, input int cp, input int r, input int c,
			input int at, input bit known, input tcbw_pkg::result_t want);
		stim_t s;
		s.act = act;
		s.cp = 21'(cp);
		s.r = 7'(r);
		s.c = 7'(c);
		s.at = 8'(at);
		s.known = known;
		s.want = want;
		directed_rows.push_back(s);
	endtask

	function automatic stim_t random_item();
		stim_t s;
		int pick;
		s = '0;
		s.at = 8'($urandom);
		s.r = 7'($urandom);
		s.c = 7'($urandom);
		s.cp = 21'($urandom);
		pick = $urandom_range(0, 99);
		if (pick < 55) begin
			s.act = tcbw_pkg::ACT_PUT;
			case ($urandom_range(0, 19))
				0: s.cp = tcbw_pkg::CH_CR;
				1: s.cp = tcbw_pkg::CH_LF;
				2: s.cp = tcbw_pkg::CH_BS;
				3, 4: s.cp = tcbw_pkg::CH_TAB;
				5: s.cp = 21'($urandom_range(0, 31));
				6: s.cp = 21'h1FFFFF;
				7, 8: ;
				default: s.cp = 21'($urandom_range(32, 126));
			endcase
		end else if (pick < 72) begin
			s.act = tcbw_pkg::ACT_MOVE;
			if ($urandom_range(0, 4) != 0) begin
				s.r = 7'($urandom_range(0, live_rows() - 1));
				s.c = 7'($urandom_range(0, live_cols() - 1));
			end
		end else if (pick < 99) begin
			s.act = tcbw_pkg::ACT_READ;
			case ($urandom_range(0, 4))
				0, 1: begin
					s.r = 7'(last_wr_r);
					s.c = 7'(last_wr_c);
				end
				2, 3: begin
					s.r = 7'($urandom_range(0, live_rows() - 1));
					s.c = 7'($urandom_range(0, live_cols() - 1));
				end
				default: ;
			endcase
		end else begin
			s.act = tcbw_pkg::ACT_CLEAR;
		end
		return s;
	endfunction

	task automatic send_item(input stim_t s);
		if (idle_on && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		in_valid <= 1'b1;
		action <= s.act;
		codepoint <= s.cp;
		row <= s.r;
		col <= s.c;
		attr <= s.at;
		tag_known <= s.known;
		tag_want <= s.want;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	// hold off until every result is back, then let the block settle
	task automatic wait_drained();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (pending_results.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic program_screen(input logic [7:0] c, input logic [7:0] r);
		cfg_we <= 1'b1;
		cfg_index <= tcbw_pkg::CFG_COLS;
		cfg_data <= c;
		@(posedge clk);
		cols_reg = c;
		cur_r = 0;
		cur_c = 0;
		cfg_index <= tcbw_pkg::CFG_ROWS;
		cfg_data <= r;
		@(posedge clk);
		rows_reg = r[6:0];
		cur_r = 0;
		cur_c = 0;
		cfg_we <= 1'b0;
	endtask

	initial begin
		logic [7:0] ph_cols [NUM_PHASES];
		logic [7:0] ph_rows [NUM_PHASES];
		tcbw_pkg::result_t none;

		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= tcbw_pkg::CFG_COLS;
		cfg_data <= '0;
		in_valid <= 1'b0;
		action <= tcbw_pkg::ACT_PUT;
		codepoint <= '0;
		row <= '0;
		col <= '0;
		attr <= '0;
		tag_known <= 1'b0;
		tag_want <= '0;

		cols_reg = tcbw_pkg::COLS_RESET;
		rows_reg = tcbw_pkg::ROWS_RESET;
		last_wr_r = 0;
		last_wr_c = 0;
		blank_model();
		none = '0;

		// zero and oversized registers saturate; the last phase is random
		ph_cols[0] = 8'd0;   ph_rows[0] = 8'd0;
		ph_cols[1] = 8'd255; ph_rows[1] = 8'd255;
		ph_cols[2] = 8'd1;   ph_rows[2] = 8'd1;
		ph_cols[3] = 8'd128; ph_rows[3] = 8'd64;
		ph_cols[4] = 8'd10;  ph_rows[4] = 8'd3;
		ph_cols[5] = 8'($urandom_range(0, 255));
		ph_rows[5] = 8'($urandom_range(0, 255));

		// default 80x25 screen after reset
		add_row(tcbw_pkg::ACT_READ, 0, 0, 0, 0, 1,
			fixed_result(0, 0, 0, 0, 'h20, 0, 0, 0));
		add_row(tcbw_pkg::ACT_READ, 0, 24, 79, 0, 1,
			fixed_result(0, 0, 24, 79, 'h20, 0, 0, 0));
		add_row(tcbw_pkg::ACT_READ, 0, 25, 0, 0, 1, fixed_result(1, 0, 0, 0, 0, 0, 0, 0));
		add_row(tcbw_pkg::ACT_READ, 0, 0, 80, 0, 1, fixed_result(1, 0, 0, 0, 0, 0, 0, 0));
		add_row(tcbw_pkg::ACT_MOVE, 0, 127, 127, 0, 1,
			fixed_result(1, 0, 0, 0, 0, 0, 0, 0));
		add_row(tcbw_pkg::ACT_PUT, 'h41, 0, 0, 'hFF, 1,
			fixed_result(0, 1, 0, 0, 'h41, 'hFF, 0, 1));
		add_row(tcbw_pkg::ACT_PUT, 'h1FFFFF, 0, 0, 0, 1,
			fixed_result(0, 1, 0, 1, 'h1FFFFF, 0, 0, 2));
		// control codes other than CR/LF/BS/TAB land as blanks
		add_row(tcbw_pkg::ACT_PUT, 'h1F, 0, 0, 'h5A, 1,
			fixed_result(0, 1, 0, 2, 'h20, 'h5A, 0, 3));
		add_row(tcbw_pkg::ACT_PUT, 0, 0, 0, 'h01, 1,
			fixed_result(0, 1, 0, 3, 'h20, 'h01, 0, 4));
		add_row(tcbw_pkg::ACT_PUT, tcbw_pkg::CH_TAB, 0, 0, 'hA5, 0, none);
		add_row(tcbw_pkg::ACT_PUT, tcbw_pkg::CH_BS, 0, 0, 0, 1,
			fixed_result(0, 0, 0, 0, 0, 0, 0, 7));
		add_row(tcbw_pkg::ACT_PUT, tcbw_pkg::CH_CR, 0, 0, 0, 1,
			fixed_result(0, 0, 0, 0, 0, 0, 0, 0));
		add_row(tcbw_pkg::ACT_PUT, tcbw_pkg::CH_BS, 0, 0, 0, 1,
			fixed_result(0, 0, 0, 0, 0, 0, 0, 0));
		add_row(tcbw_pkg::ACT_PUT, tcbw_pkg::CH_LF, 0, 0, 0, 1,
			fixed_result(0, 0, 0, 0, 0, 0, 1, 0));
		add_row(tcbw_pkg::ACT_MOVE, 0, 24, 79, 0, 1,
			fixed_result(0, 0, 0, 0, 0, 0, 24, 79));
		add_row(tcbw_pkg::ACT_PUT, 'h5A, 0, 0, 'h80, 1,
			fixed_result(0, 1, 24, 79, 'h5A, 'h80, 24, 0));
		add_row(tcbw_pkg::ACT_PUT, tcbw_pkg::CH_LF, 0, 0, 0, 1,
			fixed_result(0, 0, 0, 0, 0, 0, 24, 0));
		add_row(tcbw_pkg::ACT_MOVE, 0, 24, 78, 0, 1,
			fixed_result(0, 0, 0, 0, 0, 0, 24, 78));
		add_row(tcbw_pkg::ACT_PUT, tcbw_pkg::CH_TAB, 0, 0, 'h3C, 0, none);
		add_row(tcbw_pkg::ACT_READ, 0, 24, 79, 0, 0, none);
		add_row(tcbw_pkg::ACT_READ, 0, 0, 0, 0, 0, none);
		add_row(tcbw_pkg::ACT_PUT, 'h10FFFF, 0, 0, 'h7F, 0, none);
		add_row(tcbw_pkg::ACT_CLEAR, 0, 0, 0, 0, 1, fixed_result(0, 0, 0, 0, 0, 0, 0, 0));
		add_row(tcbw_pkg::ACT_READ, 0, 0, 0, 0, 1,
			fixed_result(0, 0, 0, 0, 'h20, 0, 0, 0));
		add_row(tcbw_pkg::ACT_PUT, 'h7E, 127, 127, 'hFF, 0, none);

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i])
			send_item(directed_rows[i]);
		wait_drained();

		for (int p = 0; p < NUM_PHASES; p++) begin
			if (p == NUM_PHASES - 1)
				idle_on = 1'b0;
			program_screen(ph_cols[p], ph_rows[p]);
			for (int k = 0; k < RAND_PER_PHASE; k++)
				send_item(random_item());
			wait_drained();
		end

		if (err_count == 0)
			$display("text_cell_buffer_writer regression: pass");
		else
			$display("text_cell_buffer_writer regression: fail");
		$finish;
	end

endmodule

`default_nettype wire

### filelist.f
rtl/tcbw_pkg.sv
rtl/text_cell_buffer_writer.sv
dv/text_cell_buffer_writer_tb.sv
